[rtl/fba_pkg.sv]
// fba_pkg: shared constants and types of the frame bitmap allocator
// no dependencies; used by the channel interfaces and frame_bitmap_allocator
package fba_pkg;

    localparam int FRAME_W     = 12;
    localparam int LEN_W       = 13;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int ADDR_W      = FRAME_W - BIT_W;
    localparam int BITMAP_WORDS = 1 << ADDR_W;
    localparam int CNT_W       = 6;

    localparam logic [LEN_W-1:0]  FRAME_FIELD_LIMIT = 13'h1000;
    localparam logic [LEN_W-1:0]  FRAME_CAP =
        (BITMAP_WORDS * WORD_W < 4096) ? LEN_W'(BITMAP_WORDS * WORD_W) : FRAME_FIELD_LIMIT;
    localparam logic [LEN_W-1:0]  FRAME_COUNT_RESET = 13'h1000;
    localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_RESERVE = 2'd2,
        MODE_TEST    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } t_state;

endpackage

[rtl/fba_if.sv]
// fba_if: request and response channels of the frame bitmap allocator
// depends on fba_pkg for field widths
interface fba_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [fba_pkg::FRAME_W-1:0] frame_index;
    logic [fba_pkg::LEN_W-1:0]   run_length;

    modport source (output valid, mode, frame_index, run_length, input ready);
    modport sink   (input valid, mode, frame_index, run_length, output ready);
endinterface

interface fba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fba_pkg::FRAME_W-1:0] base_frame;
    logic                        frame_used;

    modport source (output valid, status, base_frame, frame_used, input ready);
    modport sink   (input valid, status, base_frame, frame_used, output ready);
endinterface

[rtl/frame_bitmap_allocator.sv]
// frame_bitmap_allocator: first-fit page frame allocator over a used/free bitmap
// depends on fba_pkg and on fba_req_if / fba_rsp_if from fba_if.sv

// The bitmap lives in a 128 x 32 synchronous memory, one bit per frame, with a
// valid flag per word so that reset frees every frame at once. One request is
// worked on at a time; a new request is taken while the previous response still
// waits in the output register. A test reads the word that holds the frame and
// passes through S_TEST to S_DONE. Free and reserve go straight to the
// read-modify-write, which streams one word per cycle through the memory port
// over every bitmap word the run touches. An allocation scans one word per
// cycle from word 0 up to the word holding the run (at most the managed frame
// count, frame_count capped at 4096, over 32 rounded up: 128 words), then marks
// the run used through S_RMW_RD and one S_RMW_WR per word of the run.
module frame_bitmap_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fba_pkg::LEN_W-1:0] i_cfg_wdata,
    fba_req_if.sink                   i_req,
    fba_rsp_if.source                 o_rsp
);

    localparam int WW = fba_pkg::WORD_W;
    localparam int AW = fba_pkg::ADDR_W;
    localparam int BW = fba_pkg::BIT_W;
    localparam int FW = fba_pkg::FRAME_W;
    localparam int LW = fba_pkg::LEN_W;
    localparam int CW = fba_pkg::CNT_W;

    function automatic logic [CW-1:0] low_ones(input logic [WW-1:0] f);
        logic [CW-1:0] n;
        n = CW'(WW);
        for (int i = WW - 1; i >= 0; i--) begin
            if (!f[i]) n = CW'(i);
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] high_ones(input logic [WW-1:0] f);
        logic [CW-1:0] n;
        n = CW'(WW);
        for (int i = 0; i < WW; i++) begin
            if (!f[i]) n = CW'(WW - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [BW-1:0] lowest_set(input logic [WW-1:0] m);
        logic [BW-1:0] p;
        p = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (m[i]) p = BW'(i);
        end
        return p;
    endfunction

    // positions where a free run of len frames starts inside the word
    function automatic logic [WW-1:0] fit_starts(input logic [WW-1:0] f,
                                                 input logic [CW-1:0] len);
        logic [CW-1:0][WW-1:0] r;
        logic [WW-1:0]         m;
        logic [CW-1:0]         off;
        r[0] = f;
        for (int j = 0; j < CW - 1; j++) begin
            r[j+1] = r[j] & (r[j] >> (1 << j));
        end
        m   = fba_pkg::WORD_ONES;
        off = '0;
        for (int j = 0; j < CW; j++) begin
            if (len[j]) begin
                m   = m & (r[j] >> off);
                off = off + CW'(1 << j);
            end
        end
        return m;
    endfunction

    logic [WW-1:0] mem [fba_pkg::BITMAP_WORDS];
    logic [fba_pkg::BITMAP_WORDS-1:0] r_valid;
    logic [WW-1:0] r_rd_data;
    logic          r_rd_valid;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [WW-1:0] mem_wdata;

    fba_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_frame_count;
    logic [1:0]      r_mode, n_mode;
    logic [LW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_addr, n_addr;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [FW-1:0]   r_lo, n_lo;
    logic [FW-1:0]   r_hi, n_hi;
    logic            r_set, n_set;
    fba_pkg::t_status r_status, n_status;
    logic [FW-1:0]   r_base, n_base;
    logic            r_used, n_used;
    logic            r_out_valid, n_out_valid;
    fba_pkg::t_status r_out_status, n_out_status;
    logic [FW-1:0]   r_out_base, n_out_base;
    logic            r_out_used, n_out_used;

    logic [LW-1:0] lim;
    logic          req_fire;
    logic [WW-1:0] word;
    logic [FW-1:0] wbase;
    logic [LW-1:0] next_base;
    logic          last_word;
    logic [WW-1:0] lim_mask;
    logic [WW-1:0] free_bits;
    logic [CW-1:0] tz;
    logic [CW-1:0] lz;
    logic          len_small;
    logic [WW-1:0] starts;
    logic          carry_hit;
    logic          inner_hit;
    logic [FW-1:0] start;
    logic [FW-1:0] start_hi;
    logic [WW-1:0] lo_mask;
    logic [WW-1:0] hi_mask;
    logic [FW-1:0] req_hi;

    assign lim = (r_frame_count < fba_pkg::FRAME_CAP) ? r_frame_count : fba_pkg::FRAME_CAP;
    assign req_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == fba_pkg::S_IDLE);

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.base_frame = r_out_base;
    assign o_rsp.frame_used = r_out_used;

    // scan datapath
    assign word      = r_rd_valid ? r_rd_data : '0;
    assign wbase     = {r_addr, BW'(0)};
    assign next_base = {(r_addr + 1'b1) == '0 ? 1'b1 : 1'b0, r_addr + 1'b1, BW'(0)};
    assign last_word = next_base >= lim;
    assign lim_mask  = (last_word && lim[BW-1:0] != '0)
                       ? ~(fba_pkg::WORD_ONES << lim[BW-1:0])
                       : fba_pkg::WORD_ONES;
    assign free_bits = ~word & lim_mask;
    assign tz        = low_ones(free_bits);
    assign lz        = high_ones(free_bits);
    assign len_small = (r_len <= LW'(WW));
    assign starts    = fit_starts(free_bits, r_len[CW-1:0]);
    assign carry_hit = ({1'b0, r_cnt} + (LW+1)'(tz)) >= {1'b0, r_len};
    assign inner_hit = len_small && (starts != '0);
    assign start     = carry_hit ? (wbase - r_cnt[FW-1:0])
                                 : (wbase | FW'(lowest_set(starts)));
    assign start_hi  = FW'({1'b0, start} + r_len - 1'b1);
    assign req_hi    = FW'({1'b0, i_req.frame_index} + i_req.run_length - 1'b1);

    // read-modify-write masks
    assign lo_mask   = (r_addr == r_lo[FW-1:BW]) ? (fba_pkg::WORD_ONES << r_lo[BW-1:0])
                                                 : fba_pkg::WORD_ONES;
    assign hi_mask   = (r_addr == r_hi[FW-1:BW])
                       ? (fba_pkg::WORD_ONES >> (BW'(WW - 1) - r_hi[BW-1:0]))
                       : fba_pkg::WORD_ONES;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_len        = r_len;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_set        = r_set;
        n_status     = r_status;
        n_base       = r_base;
        n_used       = r_used;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_base   = r_out_base;
        n_out_used   = r_out_used;
        mem_we       = 1'b0;
        mem_wdata    = r_set ? (word | (lo_mask & hi_mask)) : (word & ~(lo_mask & hi_mask));
        mem_raddr    = r_addr;
        unique case (r_state)
            fba_pkg::S_IDLE: begin
                mem_raddr = i_req.frame_index[FW-1:BW];
                if (req_fire) begin
                    n_mode   = i_req.mode;
                    n_len    = i_req.run_length;
                    n_status = fba_pkg::ST_OK;
                    n_base   = '0;
                    n_used   = 1'b0;
                    n_lo     = i_req.frame_index;
                    n_hi     = req_hi;
                    n_addr   = i_req.frame_index[FW-1:BW];
                    n_set    = (fba_pkg::t_mode'(i_req.mode) == fba_pkg::MODE_RESERVE);
                    unique case (fba_pkg::t_mode'(i_req.mode))
                        fba_pkg::MODE_ALLOC: begin
                            mem_raddr = '0;
                            n_addr    = '0;
                            n_cnt     = '0;
                            if (i_req.run_length == '0) begin
                                n_status = fba_pkg::ST_RANGE;
                                n_state  = fba_pkg::S_DONE;
                            end else if (lim == '0) begin
                                n_status = fba_pkg::ST_NO_SPACE;
                                n_state  = fba_pkg::S_DONE;
                            end else begin
                                n_state = fba_pkg::S_SCAN;
                            end
                        end
                        fba_pkg::MODE_FREE, fba_pkg::MODE_RESERVE: begin
                            if (i_req.run_length == '0 ||
                                ({2'b00, i_req.frame_index} + {1'b0, i_req.run_length}) >
                                {1'b0, lim}) begin
                                n_status = fba_pkg::ST_RANGE;
                                n_state  = fba_pkg::S_DONE;
                            end else begin
                                n_state = fba_pkg::S_RMW_WR;
                            end
                        end
                        fba_pkg::MODE_TEST: begin
                            if ({1'b0, i_req.frame_index} >= lim) begin
                                n_status = fba_pkg::ST_RANGE;
                                n_state  = fba_pkg::S_DONE;
                            end else begin
                                n_state = fba_pkg::S_TEST;
                            end
                        end
                        default: n_state = fba_pkg::S_DONE;
                    endcase
                end
            end
            fba_pkg::S_TEST: begin
                n_used  = word[r_lo[BW-1:0]];
                n_state = fba_pkg::S_DONE;
            end
            fba_pkg::S_SCAN: begin
                mem_raddr = r_addr + 1'b1;
                if (carry_hit || inner_hit) begin
                    n_base  = start;
                    n_lo    = start;
                    n_hi    = start_hi;
                    n_addr  = start[FW-1:BW];
                    n_set   = 1'b1;
                    n_state = fba_pkg::S_RMW_RD;
                end else if (last_word) begin
                    n_status = fba_pkg::ST_NO_SPACE;
                    n_state  = fba_pkg::S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                    n_cnt  = (tz == CW'(WW)) ? (r_cnt + LW'(WW)) : LW'(lz);
                end
            end
            fba_pkg::S_RMW_RD: begin
                n_state = fba_pkg::S_RMW_WR;
            end
            fba_pkg::S_RMW_WR: begin
                mem_raddr = r_addr + 1'b1;
                mem_we    = 1'b1;
                if (r_addr == r_hi[FW-1:BW]) begin
                    n_state = fba_pkg::S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            fba_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_base   = r_base;
                    n_out_used   = r_used;
                    n_state      = fba_pkg::S_IDLE;
                end
            end
            default: n_state = fba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fba_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_frame_count <= fba_pkg::FRAME_COUNT_RESET;
            r_valid       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_len        <= n_len;
        r_addr       <= n_addr;
        r_cnt        <= n_cnt;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_set        <= n_set;
        r_status     <= n_status;
        r_base       <= n_base;
        r_used       <= n_used;
        r_out_status <= n_out_status;
        r_out_base   <= n_out_base;
        r_out_used   <= n_out_used;
        r_rd_valid   <= r_valid[mem_raddr];
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

`ifndef SYNTH
    a_rmw_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_RMW_WR) |->
            (r_addr >= r_lo[FW-1:BW] && r_addr <= r_hi[FW-1:BW] && r_lo <= r_hi))
        else $error("bitmap write outside the requested run");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_SCAN) |-> (r_cnt <= lim && r_mode == fba_pkg::MODE_ALLOC))
        else $error("free run count beyond the managed frames");

    a_base_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != fba_pkg::ST_OK) |->
            (r_out_base == '0 && !r_out_used))
        else $error("failed item carries a base frame or test bit");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_DONE && n_state == fba_pkg::S_IDLE) |=>
            (r_out_valid && r_out_status == $past(r_status)))
        else $error("finished item not loaded into the output register");

    a_alloc_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fba_pkg::S_RMW_RD) |-> (r_base == r_lo && r_set))
        else $error("allocated run does not start at the reported base");
`endif

endmodule
